>>> src/ncs_pkg.sv
// shared types and constants for the nearest centroid search block
// no dependencies

package ncs_pkg;

    localparam int VALUE_BITS = 16;
    localparam int SLOT_PORT_W = 4;
    localparam int POS_PORT_W = 6;
    localparam int DIST_PORT_W = 38;
    localparam int CC_W = 5;
    localparam int DC_W = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int TAG_SLOT_W = 8;
    localparam int MAG_W = VALUE_BITS;
    localparam int SQ_W = 2 * VALUE_BITS;

    typedef enum logic [0:0] {
        REG_CENTROID_COUNT = 1'b0,
        REG_DIMENSION_COUNT = 1'b1
    } t_reg_index;

    typedef enum logic [0:0] {
        REQ_LOAD = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  final_elem;
        logic [TAG_SLOT_W-1:0] slot;
    } t_tag;

endpackage

>>> src/ncs_store.sv
// centroid and query memories, one write port and one registered read port each
// depends on ncs_pkg

module ncs_store import ncs_pkg::*; #(
    parameter int MAX_CENTROIDS = 16,
    parameter int MAX_DIMENSIONS = 64,
    localparam int SLOT_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_cent_we,
    input  logic                         i_query_we,
    input  logic [SLOT_W-1:0]            i_wr_slot,
    input  logic [DIM_W-1:0]             i_wr_pos,
    input  logic signed [VALUE_BITS-1:0] i_wr_value,
    input  logic                         i_rd_en,
    input  logic [SLOT_W-1:0]            i_rd_slot,
    input  logic [DIM_W-1:0]             i_rd_pos,
    output logic signed [VALUE_BITS-1:0] o_query_value,
    output logic signed [VALUE_BITS-1:0] o_cent_value
);

    logic signed [VALUE_BITS-1:0] cent_mem [MAX_CENTROIDS][MAX_DIMENSIONS];
    logic signed [VALUE_BITS-1:0] query_mem [MAX_DIMENSIONS];
    logic signed [VALUE_BITS-1:0] r_query_value;
    logic signed [VALUE_BITS-1:0] r_cent_value;

    always_ff @(posedge i_clk) begin
        if (i_cent_we) begin
            cent_mem[i_wr_slot][i_wr_pos] <= i_wr_value;
        end
        if (i_rd_en) begin
            r_cent_value <= cent_mem[i_rd_slot][i_rd_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_query_we) begin
            query_mem[i_wr_pos] <= i_wr_value;
        end
        if (i_rd_en) begin
            r_query_value <= query_mem[i_rd_pos];
        end
    end

    assign o_query_value = r_query_value;
    assign o_cent_value = r_cent_value;

endmodule

>>> src/ncs_seq.sv
// search sequencer: walks every centroid element and tags each memory read
// depends on ncs_pkg

module ncs_seq import ncs_pkg::*; #(
    parameter int MAX_CENTROIDS = 16,
    parameter int MAX_DIMENSIONS = 64,
    localparam int SLOT_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_trigger,
    input  logic [SLOT_W-1:0] i_cnt_last,
    input  logic [DIM_W-1:0]  i_dims_last,
    input  logic              i_done,
    output logic              o_busy,
    output logic              o_rd_en,
    output logic [SLOT_W-1:0] o_rd_slot,
    output logic [DIM_W-1:0]  o_rd_pos,
    output t_tag              o_tag
);

    t_state r_state, n_state;
    logic [SLOT_W-1:0] r_c, n_c;
    logic [DIM_W-1:0] r_d, n_d;
    logic elem_last;
    logic walk_end;

    assign elem_last = (r_d == i_dims_last);
    assign walk_end = elem_last && (r_c == i_cnt_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_c <= '0;
            r_d <= '0;
        end else begin
            r_state <= n_state;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_c = r_c;
        n_d = r_d;
        unique case (r_state)
            ST_IDLE: begin
                if (i_trigger) begin
                    n_state = ST_SEARCH;
                    n_c = '0;
                    n_d = '0;
                end
            end
            ST_SEARCH: begin
                if (walk_end) begin
                    n_state = ST_DRAIN;
                end
                if (elem_last) begin
                    n_d = '0;
                    n_c = r_c + 1'b1;
                end else begin
                    n_d = r_d + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy = 1'b0;
        o_rd_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
            end
            ST_SEARCH: begin
                o_busy = 1'b1;
                o_rd_en = 1'b1;
            end
            ST_DRAIN: begin
                o_busy = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
        o_rd_slot = r_c;
        o_rd_pos = r_d;
        o_tag.valid = o_rd_en;
        o_tag.first = (r_d == '0);
        o_tag.last = elem_last;
        o_tag.final_elem = walk_end;
        o_tag.slot = TAG_SLOT_W'(r_c);
    end

endmodule

>>> src/ncs_distance.sv
// distance datapath: difference, square, accumulate per centroid, keep the best
// depends on ncs_pkg

module ncs_distance import ncs_pkg::*; #(
    parameter int MAX_DIMENSIONS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tag                         i_tag,
    input  logic signed [VALUE_BITS-1:0] i_query_value,
    input  logic signed [VALUE_BITS-1:0] i_cent_value,
    output logic                         o_last_seen,
    output logic                         o_done,
    output logic [SLOT_PORT_W-1:0]       o_nearest_slot,
    output logic [DIST_PORT_W-1:0]       o_nearest_distance
);

    localparam int ACC_W = SQ_W + ((MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 0);

    t_tag r_tag1, r_tag2, r_tag3;
    logic [MAG_W-1:0] r_mag;
    logic [SQ_W-1:0] r_sq;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_best;
    logic [TAG_SLOT_W-1:0] r_best_slot;
    logic r_done;
    logic [SLOT_PORT_W-1:0] r_out_slot;
    logic [DIST_PORT_W-1:0] r_out_dist;

    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS:0] diff_abs;
    logic [ACC_W-1:0] sum;
    logic take;
    logic [ACC_W-1:0] best_dist;
    logic [TAG_SLOT_W-1:0] best_slot;

    always_comb begin
        diff = {i_query_value[VALUE_BITS-1], i_query_value}
             - {i_cent_value[VALUE_BITS-1], i_cent_value};
        diff_abs = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : diff;
        sum = (r_tag3.first ? '0 : r_acc) + ACC_W'(r_sq);
        take = (r_tag3.slot == '0) || (sum < r_best);
        best_dist = take ? sum : r_best;
        best_slot = take ? r_tag3.slot : r_best_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_done <= r_tag3.valid && r_tag3.final_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= MAG_W'(diff_abs);
        r_sq <= r_mag * r_mag;
        if (r_tag3.valid) begin
            r_acc <= sum;
            if (r_tag3.last) begin
                r_best <= best_dist;
                r_best_slot <= best_slot;
            end
            if (r_tag3.final_elem) begin
                r_out_slot <= SLOT_PORT_W'(best_slot);
                r_out_dist <= DIST_PORT_W'(best_dist);
            end
        end
    end

    assign o_last_seen = r_tag3.valid && r_tag3.final_elem;
    assign o_done = r_done;
    assign o_nearest_slot = r_out_slot;
    assign o_nearest_distance = r_out_dist;

endmodule

>>> src/nearest_centroid_search.sv
// nearest centroid search: load and query words are taken while busy is low and busy
// stays low; the word that completes a query starts a walk of the clamped centroid_count *
// dimension_count elements, one element read from each memory per cycle; o_done pulses
// after the memory read, r_mag, r_sq and r_done registers, busy is high until then
// synchronous active-low reset: config registers go to 1 and 1, memories hold stale data

module nearest_centroid_search import ncs_pkg::*; #(
    parameter int MAX_CENTROIDS = 16,
    parameter int MAX_DIMENSIONS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [SLOT_PORT_W-1:0]       i_centroid_slot,
    input  logic [POS_PORT_W-1:0]        i_element_position,
    input  logic signed [VALUE_BITS-1:0] i_element_value,
    output logic                         o_done,
    output logic [SLOT_PORT_W-1:0]       o_nearest_slot,
    output logic [DIST_PORT_W-1:0]       o_nearest_distance,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int SLOT_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int DIM_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

    logic [CC_W-1:0] r_centroid_count;
    logic [DC_W-1:0] r_dimension_count;
    logic [SLOT_W-1:0] cnt_last;
    logic [DIM_W-1:0] dims_last;
    t_reg_index reg_sel;
    logic cfg_wr;

    logic accept;
    logic pos_ok;
    logic slot_ok;
    logic cent_we;
    logic query_we;
    logic trigger;
    logic [SLOT_W-1:0] wr_slot;
    logic [DIM_W-1:0] wr_pos;

    logic rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic [DIM_W-1:0] rd_pos;
    t_tag tag;
    logic signed [VALUE_BITS-1:0] query_value;
    logic signed [VALUE_BITS-1:0] cent_value;
    logic last_seen;

    // config registers
    assign reg_sel = t_reg_index'(paddr[2]);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centroid_count <= CC_W'(1);
            r_dimension_count <= DC_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_CENTROID_COUNT: r_centroid_count <= pwdata[CC_W-1:0];
                REG_DIMENSION_COUNT: r_dimension_count <= pwdata[DC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CENTROID_COUNT: prdata = APB_DATA_W'(r_centroid_count);
            REG_DIMENSION_COUNT: prdata = APB_DATA_W'(r_dimension_count);
            default: prdata = '0;
        endcase
    end

    // clamp to 1..max, kept as last index
    always_comb begin
        priority if (r_centroid_count == '0) begin
            cnt_last = '0;
        end else if (r_centroid_count > MAX_CENTROIDS) begin
            cnt_last = SLOT_W'(MAX_CENTROIDS - 1);
        end else begin
            cnt_last = SLOT_W'(r_centroid_count - 1'b1);
        end
        priority if (r_dimension_count == '0) begin
            dims_last = '0;
        end else if (r_dimension_count > MAX_DIMENSIONS) begin
            dims_last = DIM_W'(MAX_DIMENSIONS - 1);
        end else begin
            dims_last = DIM_W'(r_dimension_count - 1'b1);
        end
    end

    // word decode
    assign accept = start && !busy;
    assign pos_ok = (i_element_position < MAX_DIMENSIONS);
    assign slot_ok = (i_centroid_slot < MAX_CENTROIDS);
    assign wr_slot = SLOT_W'(i_centroid_slot);
    assign wr_pos = DIM_W'(i_element_position);
    assign cent_we = accept && pos_ok && slot_ok && (i_req_type == REQ_LOAD);
    assign query_we = accept && pos_ok && (i_req_type == REQ_QUERY);
    assign trigger = query_we && (wr_pos == dims_last);

    ncs_store #(
        .MAX_CENTROIDS(MAX_CENTROIDS),
        .MAX_DIMENSIONS(MAX_DIMENSIONS)
    ) u_store (
        .i_clk(i_clk),
        .i_cent_we(cent_we),
        .i_query_we(query_we),
        .i_wr_slot(wr_slot),
        .i_wr_pos(wr_pos),
        .i_wr_value(i_element_value),
        .i_rd_en(rd_en),
        .i_rd_slot(rd_slot),
        .i_rd_pos(rd_pos),
        .o_query_value(query_value),
        .o_cent_value(cent_value)
    );

    ncs_seq #(
        .MAX_CENTROIDS(MAX_CENTROIDS),
        .MAX_DIMENSIONS(MAX_DIMENSIONS)
    ) u_seq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_trigger(trigger),
        .i_cnt_last(cnt_last),
        .i_dims_last(dims_last),
        .i_done(last_seen),
        .o_busy(busy),
        .o_rd_en(rd_en),
        .o_rd_slot(rd_slot),
        .o_rd_pos(rd_pos),
        .o_tag(tag)
    );

    ncs_distance #(
        .MAX_DIMENSIONS(MAX_DIMENSIONS)
    ) u_distance (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_tag(tag),
        .i_query_value(query_value),
        .i_cent_value(cent_value),
        .o_last_seen(last_seen),
        .o_done(o_done),
        .o_nearest_slot(o_nearest_slot),
        .o_nearest_distance(o_nearest_distance)
    );

    // a completing query word always starts a search
    a_trigger_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trigger |=> busy)
        else $error("search did not start");

    // a result only appears once the search has released busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    // the end of a search is followed by exactly one result strobe
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_done ##1 !o_done))
        else $error("missing or repeated result");

endmodule
